[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[design/fmmu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmmu_pkg
// Shared types and constants of the float matrix multiply unit.
// ----------------------------------------------------------------------------
package fmmu_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam logic [3:0] SIZE_RESET = 4'd8;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_ADD = 1'b1
	} fpu_op_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} fpu_rsp_t;

endpackage

[design/fmmu_fpu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmmu_fpu
// Shared single-precision multiply / add unit, round to nearest even,
// subnormals kept; normalizes one bit or one byte per cycle.
// ----------------------------------------------------------------------------
module fmmu_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  fmmu_pkg::fpu_req_t req,
	input  logic [31:0]        x,
	input  logic [31:0]        y,
	output fmmu_pkg::fpu_rsp_t rsp,
	output logic [31:0]        result
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_NORM = 2'b10
	} fstate_t;

	fstate_t state_q;
	logic done_q;
	logic [31:0] res_q;
	logic [47:0] m_q;
	logic signed [10:0] e_q;
	logic s_q;

	logic sx, sy;
	logic [7:0] ex, ey;
	logic [22:0] fx, fy;
	logic [23:0] mx, my;
	logic signed [10:0] ex_e, ey_e;
	logic x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;

	assign sx = x[31];
	assign sy = y[31];
	assign ex = x[30:23];
	assign ey = y[30:23];
	assign fx = x[22:0];
	assign fy = y[22:0];
	assign mx = {ex != 8'd0, fx};
	assign my = {ey != 8'd0, fy};
	assign ex_e = (ex == 8'd0) ? 11'sd1 : $signed({3'b000, ex});
	assign ey_e = (ey == 8'd0) ? 11'sd1 : $signed({3'b000, ey});
	assign x_nan = (ex == 8'hFF) && (fx != 23'd0);
	assign y_nan = (ey == 8'hFF) && (fy != 23'd0);
	assign x_inf = (ex == 8'hFF) && (fx == 23'd0);
	assign y_inf = (ey == 8'hFF) && (fy == 23'd0);
	assign x_zero = (ex == 8'd0) && (fx == 23'd0);
	assign y_zero = (ey == 8'd0) && (fy == 23'd0);

	// setup: special cases, product, aligned sum
	logic sp_hit;
	logic [31:0] sp_val;
	logic [47:0] prod;
	logic x_big, s_big, s_sml, sticky;
	logic signed [10:0] e_big, e_sml, d;
	logic [47:0] m_big, m_sml, m_sh, m_al, m_sum;
	logic [47:0] set_m;
	logic signed [10:0] set_e;
	logic set_s;

	always_comb begin
		prod = mx * my;
		x_big = x[30:0] >= y[30:0];
		s_big = x_big ? sx : sy;
		s_sml = x_big ? sy : sx;
		e_big = x_big ? ex_e : ey_e;
		e_sml = x_big ? ey_e : ex_e;
		m_big = x_big ? {1'b0, mx, 23'd0} : {1'b0, my, 23'd0};
		m_sml = x_big ? {1'b0, my, 23'd0} : {1'b0, mx, 23'd0};
		d = e_big - e_sml;
		if (d >= 11'sd48) begin
			m_sh = 48'd0;
			sticky = |m_sml;
		end else begin
			m_sh = m_sml >> d[5:0];
			sticky = |(m_sml & ~({48{1'b1}} << d[5:0]));
		end
		m_al = m_sh | {47'd0, sticky};
		m_sum = (s_big == s_sml) ? (m_big + m_al) : (m_big - m_al);

		sp_hit = 1'b0;
		sp_val = fmmu_pkg::CANON_NAN;
		if (req.op == fmmu_pkg::OP_MUL) begin
			set_m = prod;
			set_e = ex_e + ey_e - 11'sd127;
			set_s = sx ^ sy;
			if (x_nan || y_nan || (x_inf && y_zero) || (y_inf && x_zero)) begin
				sp_hit = 1'b1;
			end else if (x_inf || y_inf) begin
				sp_hit = 1'b1;
				sp_val = {sx ^ sy, 8'hFF, 23'd0};
			end
		end else begin
			set_m = m_sum;
			set_e = e_big;
			set_s = (m_sum == 48'd0) ? (sx & sy) : s_big;
			if (x_nan || y_nan || (x_inf && y_inf && (sx != sy))) begin
				sp_hit = 1'b1;
			end else if (x_inf) begin
				sp_hit = 1'b1;
				sp_val = x;
			end else if (y_inf) begin
				sp_hit = 1'b1;
				sp_val = y;
			end
		end
	end

	// normalize step
	logic [47:0] nxt_m;
	logic signed [10:0] nxt_e;
	logic fin;

	always_comb begin
		nxt_m = m_q;
		nxt_e = e_q;
		fin = 1'b0;
		if (m_q[47]) begin
			nxt_m = {1'b0, m_q[47:2], m_q[1] | m_q[0]};
			nxt_e = e_q + 11'sd1;
		end else if (e_q < -11'sd47) begin
			nxt_m = {47'd0, |m_q};
			nxt_e = 11'sd1;
		end else if (e_q < 11'sd1) begin
			nxt_m = {1'b0, m_q[47:2], m_q[1] | m_q[0]};
			nxt_e = e_q + 11'sd1;
		end else if ((m_q != 48'd0) && !m_q[46] && (e_q > 11'sd1)) begin
			if ((m_q[46:39] == 8'd0) && (e_q > 11'sd8)) begin
				nxt_m = m_q << 8;
				nxt_e = e_q - 11'sd8;
			end else begin
				nxt_m = m_q << 1;
				nxt_e = e_q - 11'sd1;
			end
		end else begin
			fin = 1'b1;
		end
	end

	// round
	logic inc;
	logic [24:0] rnd;
	logic signed [10:0] r_e;
	logic [31:0] r_val;

	always_comb begin
		inc = m_q[22] & ((|m_q[21:0]) | m_q[23]);
		rnd = {1'b0, m_q[46:23]} + {24'd0, inc};
		if (rnd[24]) begin
			r_e = e_q + 11'sd1;
		end else if (rnd[23]) begin
			r_e = e_q;
		end else begin
			r_e = 11'sd0;
		end
		if (r_e >= 11'sd255) begin
			r_val = {s_q, 8'hFF, 23'd0};
		end else if (rnd[24]) begin
			r_val = {s_q, r_e[7:0], 23'd0};
		end else begin
			r_val = {s_q, r_e[7:0], rnd[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						if (sp_hit) begin
							done_q <= 1'b1;
						end else begin
							state_q <= F_NORM;
						end
					end
				end
				F_NORM: begin
					if (fin) begin
						done_q <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == F_IDLE) && req.start) begin
			res_q <= sp_val;
			m_q <= set_m;
			e_q <= set_e;
			s_q <= set_s;
		end else if (state_q == F_NORM) begin
			if (fin) begin
				res_q <= r_val;
			end else begin
				m_q <= nxt_m;
				e_q <= nxt_e;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = (state_q == F_NORM);
	assign result = res_q;

endmodule

[design/float_matrix_multiply_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_matrix_multiply_unit
// Square single-precision matrix multiply C = A*B on one shared FP unit.
// ----------------------------------------------------------------------------
// Load n*n words, one per cycle, each carrying A and B elements of the same
// row-major index; the block then emits the n*n elements of C row-major with
// tlast on the final one and takes no input until they are all delivered.
// Each C element costs n multiply-add rounds of one store read, one multiply
// and one add on the shared FP unit; a round takes longer when a sum cancels
// deeply, since the unit normalizes one bit or one byte per cycle. The result
// word is then handed off on the output stream, which waits for m_tready.
// NaN results are given as 0x7FC00000.
module float_matrix_multiply_unit #(
	parameter int MAX_DIM = fmmu_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] a_element, [63:32] b_element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] c_element
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [6:0] {
		ST_LOAD = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_MULW = 7'b0001000,
		ST_ADD  = 7'b0010000,
		ST_ADDW = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [3:0] size_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] i_q, j_q, k_q;
	logic [31:0] acc_q, prod_q, a_rd_q, b_rd_q;
	logic [31:0] a_mem [DEPTH];
	logic [31:0] b_mem [DEPTH];

	logic [DW-1:0] n_use;
	logic [CW-1:0] total;
	logic [2*DW-1:0] a_idx, b_idx;
	logic [AW-1:0] a_addr, b_addr;
	logic cfg_wr, in_acc, out_acc, k_last, i_last, j_last;

	fmmu_pkg::fpu_req_t fpu_req;
	fmmu_pkg::fpu_rsp_t fpu_rsp;
	logic [31:0] fpu_x, fpu_y, fpu_res;

	always_comb begin
		if (size_q == 4'd0) begin
			n_use = DW'(1);
		end else if (int'(size_q) > MAX_DIM) begin
			n_use = DW'(MAX_DIM);
		end else begin
			n_use = DW'(size_q);
		end
	end

	assign total = CW'(n_use) * CW'(n_use);
	assign a_idx = (2*DW)'(i_q) * (2*DW)'(n_use) + (2*DW)'(k_q);
	assign b_idx = (2*DW)'(k_q) * (2*DW)'(n_use) + (2*DW)'(j_q);
	assign a_addr = a_idx[AW-1:0];
	assign b_addr = b_idx[AW-1:0];
	assign k_last = (k_q + DW'(1)) == n_use;
	assign j_last = (j_q + DW'(1)) == n_use;
	assign i_last = (i_q + DW'(1)) == n_use;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		((paddr >> 2) == 3'(fmmu_pkg::REG_MATRIX_SIZE));
	assign prdata = {28'd0, size_q};

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign out_acc = m_tvalid && m_tready;
	assign m_tlast = m_tvalid && i_last && j_last;
	assign m_tdata = ((acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0)) ?
		fmmu_pkg::CANON_NAN : acc_q;

	always_comb begin
		fpu_req.start = (state_q == ST_MUL) || (state_q == ST_ADD);
		fpu_req.op = (state_q == ST_ADD) ? fmmu_pkg::OP_ADD : fmmu_pkg::OP_MUL;
		fpu_x = (state_q == ST_ADD) ? acc_q : a_rd_q;
		fpu_y = (state_q == ST_ADD) ? prod_q : b_rd_q;
	end

	fmmu_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.x      (fpu_x),
		.y      (fpu_y),
		.rsp    (fpu_rsp),
		.result (fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q <= fmmu_pkg::SIZE_RESET;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cfg_wr) begin
				size_q <= pwdata[3:0];
				cnt_q <= '0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if ((cnt_q + CW'(1)) == total) begin
							cnt_q <= '0;
							i_q <= '0;
							j_q <= '0;
							k_q <= '0;
							state_q <= ST_READ;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_MULW;
				ST_MULW: begin
					if (fpu_rsp.done) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: state_q <= ST_ADDW;
				ST_ADDW: begin
					if (fpu_rsp.done) begin
						if (k_last) begin
							state_q <= ST_OUT;
						end else begin
							k_q <= k_q + DW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						k_q <= '0;
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								state_q <= ST_LOAD;
							end else begin
								i_q <= i_q + DW'(1);
								state_q <= ST_READ;
							end
						end else begin
							j_q <= j_q + DW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && ((cnt_q + CW'(1)) == total)) begin
			acc_q <= 32'd0;
		end else if ((state_q == ST_ADDW) && fpu_rsp.done) begin
			acc_q <= fpu_res;
		end else if (out_acc) begin
			acc_q <= 32'd0;
		end
		if ((state_q == ST_MULW) && fpu_rsp.done) begin
			prod_q <= fpu_res;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_mem[cnt_q[AW-1:0]] <= s_tdata[31:0];
			b_mem[cnt_q[AW-1:0]] <= s_tdata[63:32];
		end
		if (state_q == ST_READ) begin
			a_rd_q <= a_mem[a_addr];
			b_rd_q <= b_mem[b_addr];
		end
	end

`include "assert_macros.svh"

	`ASSERT_NEVER(a_ready_valid_excl, clk, arst_n, s_tready && m_tvalid)
	`ASSERT_IMPLIES(a_load_in_range, clk, arst_n, state_q == ST_LOAD, cnt_q < total)
	`ASSERT_IMPLIES(a_fpu_start_idle, clk, arst_n, fpu_req.start, !fpu_rsp.busy)
	`ASSERT_IMPLIES(a_done_waits, clk, arst_n, fpu_rsp.done, (state_q == ST_MULW) || (state_q == ST_ADDW))

endmodule
